// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL top level.
// Included by the top level; expands to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/rdp_pkg.sv -----
// Package for the remote debug packet receiver: sizes, characters, item and record types, hex decode.
// No dependencies; used by the interfaces and all modules.
package rdp_pkg;

  localparam int BUF_DEPTH   = 2048;
  localparam int ADDR_W      = $clog2(BUF_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MASK  = 8'h7F;

  localparam logic [1:0] REC_READ    = 2'd0;
  localparam logic [1:0] REC_NAK     = 2'd1;
  localparam logic [1:0] REC_ACK     = 2'd2;
  localparam logic [1:0] REC_ACK_SEQ = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [7:0]        rx_byte;
    logic [ADDR_W-1:0] read_index;
  } rdp_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       id0;
    logic [7:0]       id1;
    logic [LEN_W-1:0] length;
    logic [7:0]       rdata;
  } rdp_rec_t;

  function automatic logic [4:0] hex_nibble(input logic [6:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c inside {[7'h61:7'h66]}) begin
      r = {1'b1, 4'(c - 7'h57)};
    end else if (c inside {[7'h30:7'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[7'h41:7'h46]}) begin
      r = {1'b1, 4'(c - 7'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rdp_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Depends on rdp_pkg for payload widths.
interface rdp_in_if;
  import rdp_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [7:0]        rx_byte;
  logic [ADDR_W-1:0] read_index;
  modport source (output valid, mode, rx_byte, read_index, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface rdp_out_if;
  import rdp_pkg::*;
  logic             valid;
  logic             ready;
  logic             tx_valid;
  logic [7:0]       tx_byte;
  logic             packet_ready;
  logic [LEN_W-1:0] packet_length;
  logic [7:0]       read_byte;
  logic             last;
  modport source (output valid, tx_valid, tx_byte, packet_ready, packet_length, read_byte,
                  last, input ready);
  modport sink   (input valid, tx_valid, tx_byte, packet_ready, packet_length, read_byte,
                  last, output ready);
endinterface

// ----- rtl/core/rdp_parser.sv -----
// Framing state machine, checksum, payload store and read port.
// Depends on rdp_pkg; emits one reply record per request that has results.
module rdp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  rdp_pkg::rdp_item_t item,
  output logic              rec_valid,
  output rdp_pkg::rdp_rec_t rec
);
  import rdp_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(BUF_DEPTH);

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             strip_r, strip_nxt;
  logic [7:0]       sh_r [3];
  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       mem_q_r;
  logic             s1_valid_r, s1_valid_nxt;
  rdp_rec_t         s1_rec_r, s1_rec_nxt;
  logic             s1_ok_r, s1_ok_nxt;
  logic             wr_en;
  logic [LEN_W-1:0] rd_addr;
  logic [4:0]       nib;
  logic [7:0]       sent;

  assign nib     = hex_nibble(item.rx_byte[6:0]);
  assign sent    = nib[4] ? {hi_r, nib[3:0]} : 8'hFF;
  assign rd_addr = LEN_W'(item.read_index) + (strip_r ? LEN_W'(3) : LEN_W'(0));

  always_comb begin
    phase_nxt    = phase_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    hi_nxt       = hi_r;
    len_nxt      = len_r;
    strip_nxt    = strip_r;
    wr_en        = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_rec_nxt   = '0;
    s1_ok_nxt    = 1'b0;
    if (acc && item.mode) begin
      s1_valid_nxt    = 1'b1;
      s1_rec_nxt.kind = REC_READ;
      s1_ok_nxt       = (LEN_W'(item.read_index) < len_r) && (rd_addr < DEPTH_L);
    end else if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if ((item.rx_byte & CH_MASK) == CH_START) begin
            phase_nxt = PH_DATA;
            sum_nxt   = 8'h00;
            cnt_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (item.rx_byte == CH_HASH) begin
            phase_nxt = PH_HIGH;
          end else begin
            wr_en   = cnt_r < DEPTH_L;
            sum_nxt = sum_r + item.rx_byte;
            cnt_nxt = cnt_r + LEN_W'(1);
            if (cnt_nxt >= DEPTH_L) begin
              phase_nxt = PH_HUNT;
            end
          end
        end
        PH_HIGH: begin
          hi_nxt    = nib[4] ? nib[3:0] : 4'hF;
          phase_nxt = PH_LOW;
        end
        default: begin
          phase_nxt    = PH_HUNT;
          s1_valid_nxt = 1'b1;
          if (sent != sum_r) begin
            s1_rec_nxt.kind = REC_NAK;
          end else if (cnt_r >= LEN_W'(3) && sh_r[2] == CH_COLON) begin
            strip_nxt         = 1'b1;
            len_nxt           = cnt_r - LEN_W'(3);
            s1_rec_nxt.kind   = REC_ACK_SEQ;
            s1_rec_nxt.id0    = sh_r[0];
            s1_rec_nxt.id1    = sh_r[1];
            s1_rec_nxt.length = len_nxt;
          end else begin
            strip_nxt         = 1'b0;
            len_nxt           = cnt_r;
            s1_rec_nxt.kind   = REC_ACK;
            s1_rec_nxt.length = cnt_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sum_r      <= 8'h00;
      cnt_r      <= '0;
      hi_r       <= 4'h0;
      len_r      <= '0;
      strip_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      hi_r       <= hi_nxt;
      len_r      <= len_nxt;
      strip_r    <= strip_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_rec_r <= s1_rec_nxt;
    s1_ok_r  <= s1_ok_nxt;
    if (wr_en && cnt_r < LEN_W'(3)) begin
      sh_r[cnt_r[1:0]] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= item.rx_byte;
    end
    if (acc && item.mode) begin
      mem_q_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_comb begin
    rec       = s1_rec_r;
    rec.rdata = s1_ok_r ? mem_q_r : 8'h00;
  end

  assign rec_valid = s1_valid_r;

endmodule

// ----- rtl/core/rdp_reply_queue.sv -----
// Reply record queue that expands each record into one or three results.
// Depends on rdp_pkg and rdp_out_if.
module rdp_reply_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rdp_pkg::rdp_rec_t          push_rec,
  output logic [rdp_pkg::QCNT_W-1:0] count,
  rdp_out_if.source                  out_ch
);
  import rdp_pkg::*;

  rdp_rec_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [1:0]        sub_r;
  rdp_rec_t          head;
  logic              pop, fire;

  assign head  = q_r[rd_ptr_r];
  assign fire  = out_ch.valid && out_ch.ready;
  assign pop   = fire && out_ch.last;
  assign count = cnt_r;

  always_comb begin
    out_ch.valid         = cnt_r != '0;
    out_ch.tx_valid      = 1'b1;
    out_ch.tx_byte       = 8'h00;
    out_ch.packet_ready  = 1'b0;
    out_ch.packet_length = '0;
    out_ch.read_byte     = 8'h00;
    out_ch.last          = 1'b1;
    case (head.kind)
      REC_READ: begin
        out_ch.tx_valid  = 1'b0;
        out_ch.read_byte = head.rdata;
      end
      REC_NAK: begin
        out_ch.tx_byte = CH_NAK;
      end
      REC_ACK: begin
        out_ch.tx_byte       = CH_ACK;
        out_ch.packet_ready  = 1'b1;
        out_ch.packet_length = head.length;
      end
      default: begin
        case (sub_r)
          2'd0: begin
            out_ch.tx_byte = CH_ACK;
            out_ch.last    = 1'b0;
          end
          2'd1: begin
            out_ch.tx_byte = head.id0;
            out_ch.last    = 1'b0;
          end
          default: begin
            out_ch.tx_byte       = head.id1;
            out_ch.packet_ready  = 1'b1;
            out_ch.packet_length = head.length;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
        sub_r    <= 2'd0;
      end else if (fire) begin
        sub_r <= sub_r + 2'd1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- rtl/core/remote_debug_packet_receiver.sv -----
// Top level of the remote debug packet receiver.
// Depends on rdp_pkg, rdp_if, rdp_parser, rdp_reply_queue and assert_macros.svh.
//
// Accepts one request per clock: a link byte ($payload#hh framing, mod-256
// checksum, 2048-byte payload store) or a read of a stored payload byte.
// A read gives one result; a finished packet gives '-' or '+', or '+' plus
// the two echoed sequence id characters, each result its own output transfer.
// Results leave through the registered record stage and then a
// four-entry reply queue; requests stall only while the queue and the
// record stage together are full, so the input runs at one request per
// cycle unless the result side stalls or replies pile up. The payload
// store has one write port and one registered read port.
`include "assert_macros.svh"

module remote_debug_packet_receiver (
  input logic       clk,
  input logic       rst_n,
  rdp_in_if.sink    in_ch,
  rdp_out_if.source out_ch
);
  import rdp_pkg::*;

  rdp_item_t         item;
  rdp_rec_t          rec;
  logic              rec_valid;
  logic [QCNT_W-1:0] q_cnt;
  logic              acc;

  assign in_ch.ready = (q_cnt + QCNT_W'(rec_valid)) < QCNT_W'(QUEUE_DEPTH);
  assign acc         = in_ch.valid && in_ch.ready;
  assign item        = '{mode: in_ch.mode, rx_byte: in_ch.rx_byte,
                         read_index: in_ch.read_index};

  rdp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (item),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  rdp_reply_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_valid),
    .push_rec (rec),
    .count    (q_cnt),
    .out_ch   (out_ch)
  );

  `ASSERT_NEVER(a_queue_bound, clk, rst_n, q_cnt > QCNT_W'(QUEUE_DEPTH), "reply queue overrun")
  `ASSERT_CLK(a_read_record, clk, rst_n, (acc && in_ch.mode) |=> rec_valid, "read lost")
  `ASSERT_CLK(a_ready_last, clk, rst_n, (out_ch.valid && out_ch.packet_ready) |-> (out_ch.tx_valid && out_ch.last), "packet_ready off last")

endmodule

// ----- tb/rdp_reply_checker.sv -----
// Scoreboard for the remote debug packet receiver: predicts the replies from
// every accepted request and compares them with the result channel.
// Depends on rdp_pkg and the rdp_in_if / rdp_out_if interfaces.
module rdp_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  rdp_in_if           in_ch,
  rdp_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rdp_pkg::*;

  typedef enum logic [1:0] {HUNT, BODY, SUM_HI, SUM_LO} link_phase_t;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             packet_ready;
    logic [LEN_W-1:0] packet_length;
    logic [7:0]       read_byte;
    logic             last;
  } reply_t;

  link_phase_t      phase;
  logic [7:0]       sum_acc;
  logic [LEN_W-1:0] body_len;
  logic [7:0]       sent_hi;
  logic [7:0]       body_mem [BUF_DEPTH];
  logic [LEN_W-1:0] kept_len;
  logic             has_seq_id;
  reply_t           due_q [$];
  int unsigned      n_bad = 0;
  int unsigned      n_due = 0;

  assign fail_count = n_bad;
  assign pending    = n_due;

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    logic [6:0] m;
    logic       ok;
    m  = c[6:0];
    v  = 4'h0;
    ok = 1'b1;
    if (m >= "0" && m <= "9") begin
      v = m[3:0];
    end else if ((m >= "a" && m <= "f") || (m >= "A" && m <= "F")) begin
      v = m[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic reply_t reply(input logic txv, input logic [7:0] txb, input logic rdy,
                                   input logic [LEN_W-1:0] len, input logic [7:0] rb,
                                   input logic lst);
    reply_t r;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.packet_ready  = rdy;
    r.packet_length = len;
    r.read_byte     = rb;
    r.last          = lst;
    return r;
  endfunction

  task automatic take_request(input logic mode, input logic [7:0] rx,
                              input logic [ADDR_W-1:0] idx);
    logic [LEN_W-1:0] addr;
    logic [3:0]       nib;
    logic [7:0]       sent;
    logic [7:0]       rb;
    if (mode) begin
      addr = LEN_W'(idx) + (has_seq_id ? LEN_W'(3) : LEN_W'(0));
      rb   = 8'h00;
      if (LEN_W'(idx) < kept_len && addr < BUF_DEPTH) rb = body_mem[addr[ADDR_W-1:0]];
      due_q.push_back(reply(1'b0, 8'h00, 1'b0, LEN_W'(0), rb, 1'b1));
    end else begin
      case (phase)
        HUNT: begin
          if ((rx & CH_MASK) == CH_START) begin
            phase    = BODY;
            sum_acc  = 8'h00;
            body_len = LEN_W'(0);
          end
        end
        BODY: begin
          if (rx == CH_HASH) begin
            phase = SUM_HI;
          end else begin
            body_mem[body_len[ADDR_W-1:0]] = rx;
            sum_acc  = sum_acc + rx;
            body_len = body_len + 1'b1;
            if (body_len == BUF_DEPTH) phase = HUNT;
          end
        end
        SUM_HI: begin
          sent_hi = hex_digit(rx, nib) ? {nib, 4'h0} : 8'hF0;
          phase   = SUM_LO;
        end
        SUM_LO: begin
          sent  = hex_digit(rx, nib) ? (sent_hi | {4'h0, nib}) : 8'hFF;
          phase = HUNT;
          if (sent != sum_acc) begin
            due_q.push_back(reply(1'b1, CH_NAK, 1'b0, LEN_W'(0), 8'h00, 1'b1));
          end else if (body_len >= 3 && body_mem[2] == CH_COLON) begin
            has_seq_id = 1'b1;
            kept_len   = body_len - LEN_W'(3);
            due_q.push_back(reply(1'b1, CH_ACK, 1'b0, LEN_W'(0), 8'h00, 1'b0));
            due_q.push_back(reply(1'b1, body_mem[0], 1'b0, LEN_W'(0), 8'h00, 1'b0));
            due_q.push_back(reply(1'b1, body_mem[1], 1'b1, kept_len, 8'h00, 1'b1));
          end else begin
            has_seq_id = 1'b0;
            kept_len   = body_len;
            due_q.push_back(reply(1'b1, CH_ACK, 1'b1, kept_len, 8'h00, 1'b1));
          end
        end
      endcase
    end
  endtask

  task automatic note_bad(input string what, input reply_t want, input reply_t got);
    if (n_bad < 10) begin
      $display("tb: %s at %0t: expected tx %0b %h ready %0b len %0d read %h last %0b",
               what, $time, want.tx_valid, want.tx_byte, want.packet_ready,
               want.packet_length, want.read_byte, want.last);
      $display("tb:   got tx %0b %h ready %0b len %0d read %h last %0b",
               got.tx_valid, got.tx_byte, got.packet_ready, got.packet_length,
               got.read_byte, got.last);
    end
    n_bad++;
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = reply(out_ch.tx_valid, out_ch.tx_byte, out_ch.packet_ready, out_ch.packet_length,
                out_ch.read_byte, out_ch.last);
    if (due_q.size() == 0) begin
      note_bad("result with nothing pending", '0, got);
    end else begin
      want = due_q.pop_front();
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.packet_ready !== want.packet_ready ||
          got.packet_length !== want.packet_length ||
          got.read_byte !== want.read_byte || got.last !== want.last) begin
        note_bad("mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = HUNT;
      sum_acc    = 8'h00;
      body_len   = LEN_W'(0);
      sent_hi    = 8'h00;
      kept_len   = LEN_W'(0);
      has_seq_id = 1'b0;
      due_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_request(in_ch.mode, in_ch.rx_byte, in_ch.read_index);
      end
      if (out_ch.valid && out_ch.ready) check_reply();
    end
    n_due <= due_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the remote debug packet receiver bench: clock, reset, request and
// result-side stimulus, verdict. Depends on rdp_pkg, rdp_if and rdp_reply_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdp_pkg::*;

  localparam int LONG_HOLD    = 160;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_ITEMS   = 60;
  localparam logic [7:0] JUNK [10] = '{8'h67, 8'h47, 8'h2F, 8'h3A, 8'h40, 8'h60,
                                       8'h00, 8'h7F, 8'hC7, 8'hA4};

  typedef enum int {SUM_GOOD, SUM_WRONG, HI_BAD, LO_BAD} sum_kind_t;
  typedef logic [7:0] byte_q_t [$];

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent_items = 0;
  bit          idling = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          store_filled = 1'b0;

  rdp_in_if  in_ch ();
  rdp_out_if out_ch ();

  remote_debug_packet_receiver uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rdp_reply_checker replies (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : result_side
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic offer(input logic mode, input logic [7:0] rx,
                       input logic [ADDR_W-1:0] idx, input bit tally);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.rx_byte    <= rx;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tally) sent_items++;
  endtask

  task automatic link(input logic [7:0] b);
    offer(1'b0, b, ADDR_W'($urandom), 1'b1);
  endtask

  task automatic read_back(input int idx);
    offer(1'b1, 8'($urandom), ADDR_W'(idx), 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int small_index();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    if (b == CH_HASH) b = CH_HASH ^ 8'h80;
    return b;
  endfunction

  function automatic byte_q_t make_body(input int len, input bit seq);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(body_byte());
    if (seq && len >= 3) q[2] = CH_COLON;
    return q;
  endfunction

  function automatic byte_q_t text_body(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 10) c = 8'h30 + nib;
    else if ($urandom_range(0, 1) == 0) c = 8'h57 + nib;
    else c = 8'h37 + nib;
    if ($urandom_range(0, 5) == 0) c[7] = 1'b1;
    return c;
  endfunction

  function automatic sum_kind_t pick_kind();
    int n;
    n = $urandom_range(0, 99);
    if (n < 70) return SUM_GOOD;
    if (n < 82) return SUM_WRONG;
    if (n < 91) return HI_BAD;
    return LO_BAD;
  endfunction

  task automatic frame(input byte_q_t body, input sum_kind_t kind);
    logic [7:0] sum;
    sum = 8'h00;
    foreach (body[i]) sum += body[i];
    if (kind == SUM_WRONG) sum += 8'($urandom_range(1, 255));
    link(($urandom_range(0, 3) == 0) ? (CH_START | 8'h80) : CH_START);
    foreach (body[i]) begin
      if (store_filled && $urandom_range(0, 40) == 0) read_back(small_index());
      link(body[i]);
    end
    link(CH_HASH);
    link((kind == HI_BAD) ? JUNK[$urandom_range(0, 9)] : hex_char(sum[7:4]));
    link((kind == LO_BAD) ? JUNK[$urandom_range(0, 9)] : hex_char(sum[3:0]));
  endtask

  initial begin : request_side
    byte_q_t body;
    int      n;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= 1'b0;
    in_ch.rx_byte    <= 8'h00;
    in_ch.read_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    store_filled = 1'b1;
    read_back(0);
    read_back(2047);

    body.delete();
    frame(body, SUM_GOOD);
    body.delete();
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h80);
    body.push_back(CH_START);
    body.push_back(CH_HASH ^ 8'h80);
    frame(body, SUM_GOOD);
    read_back(0);
    read_back(4);
    read_back(5);
    frame(text_body("12:ab"), SUM_GOOD);
    read_back(0);
    read_back(1);
    read_back(2);
    read_back(2047);
    frame(text_body("xy:"), SUM_GOOD);
    frame(text_body("q:"), SUM_GOOD);
    frame(text_body("mn:g"), SUM_WRONG);
    frame(text_body("hi"), HI_BAD);
    body.delete();
    body.push_back(8'hFF);
    frame(body, LO_BAD);
    body.delete();
    body.push_back(8'hF3);
    frame(body, HI_BAD);

    // stall the result side while reads keep coming
    hold_req = 1'b1;
    while (!hold_done) @(posedge clk);
    repeat (40) read_back(small_index());
    drain();

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items >= RANDOM_ITEMS - CALM_ITEMS) idling = 1'b0;
      n = $urandom_range(0, 99);
      if (n < 55) begin
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        frame(make_body(n, $urandom_range(0, 3) == 0), pick_kind());
      end else if (n < 80) begin
        read_back(small_index());
      end else if (n < 94) begin
        repeat ($urandom_range(1, 4)) offer(1'b0, 8'($urandom), ADDR_W'($urandom), 1'b0);
      end else if (n < 96) begin
        drain();
      end else begin
        // broken frame: start, a few bytes, no trailer
        link(CH_START);
        repeat ($urandom_range(0, 5)) link(body_byte());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rdp_pkg.sv
rtl/core/rdp_if.sv
rtl/core/rdp_parser.sv
rtl/core/rdp_reply_queue.sv
rtl/core/remote_debug_packet_receiver.sv
tb/rdp_reply_checker.sv
tb/tb.sv
